>>> rtl/hsj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsj_pkg
// Types and constants shared by the withstand-test sample judge modules.
// ----------------------------------------------------------------------------
package hsj_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int SUM_W      = 22;
   localparam int PROD_W     = 36;
   localparam int RAW_W      = 20;
   localparam int REAL_W     = 37;
   localparam int CNT_W      = 2;

   localparam int LIM_NUM    = 11;
   localparam int LIM_DEN    = 10;
   localparam int LIM_ADD    = 10;
   localparam int SNAP_BELOW = 10;
   localparam int SNAP_ABOVE = 3;
   localparam int SHORT_TIME = 5;
   localparam int OV_TRIP    = 2;
   localparam int LOW_TRIP   = 2;
   localparam int SHORT_VOLT = 1;

   localparam logic [1:0] STAGE_OTHER  = 2'd0;
   localparam logic [1:0] STAGE_RAMP   = 2'd1;
   localparam logic [1:0] STAGE_SWITCH = 2'd2;
   localparam logic [1:0] STAGE_DWELL  = 2'd3;

   localparam logic [2:0] FAIL_NONE  = 3'd0;
   localparam logic [2:0] FAIL_REAL  = 3'd1;
   localparam logic [2:0] FAIL_HIGH  = 3'd2;
   localparam logic [2:0] FAIL_VOLT  = 3'd3;
   localparam logic [2:0] FAIL_SHORT = 3'd4;
   localparam logic [2:0] FAIL_LOW   = 3'd5;

   localparam logic [1:0] VERDICT_NONE = 2'd0;
   localparam logic [1:0] VERDICT_PASS = 2'd1;
   localparam logic [1:0] VERDICT_LOW  = 2'd2;

   localparam logic [2:0] REG_SET_VOLTAGE    = 3'd0;
   localparam logic [2:0] REG_TEST_DURATION  = 3'd1;
   localparam logic [2:0] REG_HIGH_LIMIT     = 3'd2;
   localparam logic [2:0] REG_LOW_LIMIT      = 3'd3;
   localparam logic [2:0] REG_REAL_LIMIT     = 3'd4;
   localparam logic [2:0] REG_CURRENT_OFFSET = 3'd5;
   localparam logic [2:0] REG_VOLT_GAIN      = 3'd6;
   localparam logic [2:0] REG_AMP_GAIN       = 3'd7;

   localparam logic [15:0] RST_HIGH_LIMIT = 16'hFFFF;
   localparam logic [19:0] RST_GAIN       = 20'h10000;

   typedef struct packed {
      logic [15:0]        volt_code;
      logic [15:0]        amp_code;
      logic signed [15:0] phase_cosine;
      logic [1:0]         stage;
      logic [13:0]        elapsed;
      logic               judge_on;
   } hsj_req_type;

   typedef struct packed {
      logic [15:0] voltage_out;
      logic [15:0] current_out;
      logic [15:0] real_current_out;
      logic [2:0]  fail_code;
      logic        stop_high_voltage;
      logic [1:0]  end_verdict;
   } hsj_rsp_type;

   typedef struct packed {
      logic [14:0] set_voltage;
      logic [13:0] test_duration;
      logic [15:0] high_limit;
      logic [15:0] low_limit;
      logic [15:0] real_limit;
      logic [15:0] current_offset;
      logic [19:0] volt_gain;
      logic [19:0] amp_gain;
   } hsj_cfg_type;

   typedef struct packed {
      logic load_in;
      logic mul_en;
      logic real_en;
      logic judge_load;
   } hsj_cmd_type;

   function automatic logic [15:0] sat16(input logic signed [SUM_W-1:0] x);
      logic [15:0] res;
      if (x < 0) begin
         res = 16'd0;
      end else if (x > 65535) begin
         res = 16'hFFFF;
      end else begin
         res = x[15:0];
      end
      return res;
   endfunction

   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
      return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
   endfunction

endpackage

>>> rtl/hipot_sample_judge_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hipot_sample_judge_core
// Per-sample calibration and fault judging for an AC withstand test.
// ----------------------------------------------------------------------------
// Usage: the req channel takes one sample (ADC codes, phase cosine, stage,
// elapsed time, judge enable) per transfer; the rsp channel returns one
// result per sample with calibrated voltage, currents, fail code, stop and
// end verdict. Limits, offsets and gains are set through the APB-style port
// by the user only while no sample is in flight; the block does not enforce it.
// Sequence: the input register takes the sample, then the gain multiplies,
// then the real-current multiply on the scaled current, then the judge
// step that writes the result register. A new sample is taken only once
// the sequencer is idle again, after the judge step of the previous one.
// Reset: registers take their reset values, the debounce counters and the
// fault latch clear and no result is pending.
// Stall: the result register holds while rsp_stall is high; a following
// sample is still accepted and computed, then waits in the judge step with
// req_stall high until the result register is free.
// ----------------------------------------------------------------------------
module hipot_sample_judge_core #(
   parameter int VOLT_CAL_OFFSET = 0,
   parameter int REAL_OFFSET     = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  hsj_pkg::hsj_req_type             req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output hsj_pkg::hsj_rsp_type             rsp_payload,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [hsj_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [hsj_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [hsj_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   hsj_pkg::hsj_cfg_type cfg;
   hsj_pkg::hsj_cmd_type cmd;

   hsj_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hsj_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   hsj_datapath #(
      .VOLT_CAL_OFFSET (VOLT_CAL_OFFSET),
      .REAL_OFFSET     (REAL_OFFSET)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cfg         (cfg),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/hsj_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsj_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module hsj_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [hsj_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [hsj_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [hsj_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready,
   output hsj_pkg::hsj_cfg_type             cfg
);

   hsj_pkg::hsj_cfg_type cfg_ff;
   hsj_pkg::hsj_cfg_type cfg_in;
   logic [2:0]           index;
   logic                 wr_en;

   assign index  = paddr[4:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            hsj_pkg::REG_SET_VOLTAGE:    cfg_in.set_voltage    = pwdata[14:0];
            hsj_pkg::REG_TEST_DURATION:  cfg_in.test_duration  = pwdata[13:0];
            hsj_pkg::REG_HIGH_LIMIT:     cfg_in.high_limit     = pwdata[15:0];
            hsj_pkg::REG_LOW_LIMIT:      cfg_in.low_limit      = pwdata[15:0];
            hsj_pkg::REG_REAL_LIMIT:     cfg_in.real_limit     = pwdata[15:0];
            hsj_pkg::REG_CURRENT_OFFSET: cfg_in.current_offset = pwdata[15:0];
            hsj_pkg::REG_VOLT_GAIN:      cfg_in.volt_gain      = pwdata[19:0];
            hsj_pkg::REG_AMP_GAIN:       cfg_in.amp_gain       = pwdata[19:0];
         endcase
      end
   end

   always_comb begin
      unique case (index)
         hsj_pkg::REG_SET_VOLTAGE:    prdata = 32'(cfg_ff.set_voltage);
         hsj_pkg::REG_TEST_DURATION:  prdata = 32'(cfg_ff.test_duration);
         hsj_pkg::REG_HIGH_LIMIT:     prdata = 32'(cfg_ff.high_limit);
         hsj_pkg::REG_LOW_LIMIT:      prdata = 32'(cfg_ff.low_limit);
         hsj_pkg::REG_REAL_LIMIT:     prdata = 32'(cfg_ff.real_limit);
         hsj_pkg::REG_CURRENT_OFFSET: prdata = 32'(cfg_ff.current_offset);
         hsj_pkg::REG_VOLT_GAIN:      prdata = 32'(cfg_ff.volt_gain);
         hsj_pkg::REG_AMP_GAIN:       prdata = 32'(cfg_ff.amp_gain);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_voltage    <= '0;
         cfg_ff.test_duration  <= '0;
         cfg_ff.high_limit     <= hsj_pkg::RST_HIGH_LIMIT;
         cfg_ff.low_limit      <= '0;
         cfg_ff.real_limit     <= '0;
         cfg_ff.current_offset <= '0;
         cfg_ff.volt_gain      <= hsj_pkg::RST_GAIN;
         cfg_ff.amp_gain       <= hsj_pkg::RST_GAIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/hsj_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsj_ctrl
// Sequencer: accept, scale, real current and snap, judge and hand off.
// ----------------------------------------------------------------------------
module hsj_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output hsj_pkg::hsj_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_REAL,
      ST_JUDGE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      judge_load;

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign judge_load = (state_ff == ST_JUDGE) && (!rsp_valid_ff || !rsp_stall);

   assign cmd.load_in    = (state_ff == ST_IDLE) && req_valid;
   assign cmd.mul_en     = (state_ff == ST_MUL);
   assign cmd.real_en    = (state_ff == ST_REAL);
   assign cmd.judge_load = judge_load;

   always_comb begin
      unique case (state_ff)
         ST_IDLE:  state_in = req_valid ? ST_MUL : ST_IDLE;
         ST_MUL:   state_in = ST_REAL;
         ST_REAL:  state_in = ST_JUDGE;
         ST_JUDGE: state_in = judge_load ? ST_IDLE : ST_JUDGE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (judge_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a result only appears out of the judge step
   a_valid_from_judge: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_JUDGE))
      else $error("result valid without judge step");

   // work starts only from an input transfer
   a_mul_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> $past(req_valid && !req_stall))
      else $error("sequencer left idle without a transfer");

endmodule

>>> rtl/hsj_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsj_datapath
// Gain scaling, real current, voltage snap, saturation and fault judging.
// ----------------------------------------------------------------------------
module hsj_datapath #(
   parameter int VOLT_CAL_OFFSET = 0,
   parameter int REAL_OFFSET     = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hsj_pkg::hsj_cmd_type cmd,
   input  hsj_pkg::hsj_cfg_type cfg,
   input  hsj_pkg::hsj_req_type req_payload,
   output hsj_pkg::hsj_rsp_type rsp_payload
);

   localparam int SUM_W  = hsj_pkg::SUM_W;
   localparam int PROD_W = hsj_pkg::PROD_W;
   localparam int RAW_W  = hsj_pkg::RAW_W;
   localparam int REAL_W = hsj_pkg::REAL_W;
   localparam int CNT_W  = hsj_pkg::CNT_W;
   localparam logic signed [SUM_W-1:0] VOLT_OFS = SUM_W'(VOLT_CAL_OFFSET);
   localparam logic [15:0]             REAL_OFS = REAL_OFFSET[15:0];

   hsj_pkg::hsj_req_type         in_ff;
   logic [PROD_W-1:0]            volt_prod_ff;
   logic [PROD_W-1:0]            amp_prod_ff;
   logic signed [REAL_W-1:0]     real_prod_in;
   logic signed [REAL_W-1:0]     real_prod_ff;
   logic [15:0]                  volt_out_in;
   logic [15:0]                  volt_out_ff;
   hsj_pkg::hsj_rsp_type         out_in;
   hsj_pkg::hsj_rsp_type         out_ff;

   logic [CNT_W-1:0]             over_volt_count_ff;
   logic [CNT_W-1:0]             over_volt_count_in;
   logic [CNT_W-1:0]             under_current_count_ff;
   logic [CNT_W-1:0]             under_current_count_in;
   logic                         fault_latched_ff;
   logic                         fault_latched_in;

   logic [RAW_W-1:0]             volt_raw;
   logic [RAW_W-1:0]             amp_raw;
   logic signed [RAW_W:0]        amp_raw_s;
   logic signed [SUM_W-1:0]      v_cal;
   logic signed [SUM_W-1:0]      v_snap;
   logic signed [SUM_W-1:0]      sv_s;
   logic [RAW_W-1:0]             real_pos;
   logic signed [SUM_W-1:0]      real_diff;
   logic signed [SUM_W-1:0]      cur_diff;
   logic [15:0]                  cur_out;
   logic [15:0]                  real_out;
   logic [19:0]                  volt_x_den;
   logic [19:0]                  set_x_num;
   logic                         over_lim;
   logic                         under_half;
   logic                         at_end;
   logic                         short_cond;
   logic                         active;
   logic [2:0]                   fail;
   logic [1:0]                   verdict;

   // scaling and real current
   assign volt_raw  = volt_prod_ff[PROD_W-1:16];
   assign amp_raw   = amp_prod_ff[PROD_W-1:16];
   assign amp_raw_s = $signed({1'b0, amp_raw});
   assign sv_s      = $signed({{(SUM_W-15){1'b0}}, cfg.set_voltage});

   always_comb begin
      if (cfg.real_limit != 16'd0) begin
         real_prod_in = amp_raw_s * signed'(in_ff.phase_cosine);
      end else begin
         real_prod_in = '0;
      end
   end

   always_comb begin
      if (in_ff.volt_code == 16'd0) begin
         v_cal = '0;
      end else begin
         v_cal = $signed({{(SUM_W-RAW_W){1'b0}}, volt_raw}) + VOLT_OFS;
      end
      v_snap = v_cal;
      if (in_ff.stage == hsj_pkg::STAGE_DWELL) begin
         if (v_cal <= sv_s) begin
            if (v_cal + hsj_pkg::SNAP_BELOW > sv_s) begin
               v_snap = sv_s;
            end
         end else if (sv_s + hsj_pkg::SNAP_ABOVE > v_cal) begin
            v_snap = sv_s;
         end
      end
      volt_out_in = hsj_pkg::sat16(v_snap);
   end

   // saturated outputs and judge conditions
   assign real_pos  = (real_prod_ff > 0) ? real_prod_ff[RAW_W+14:15] : '0;
   assign real_diff = $signed({{(SUM_W-RAW_W){1'b0}}, real_pos})
                      - $signed({{(SUM_W-16){1'b0}}, REAL_OFS});
   assign cur_diff  = $signed({{(SUM_W-RAW_W){1'b0}}, amp_raw})
                      - $signed({{(SUM_W-16){1'b0}}, cfg.current_offset});
   assign cur_out   = hsj_pkg::sat16(cur_diff);
   assign real_out  = hsj_pkg::sat16(real_diff);

   // v > set*11/10 + 10 without a divider: 10*v > 11*set + 100
   assign volt_x_den = 20'(volt_out_ff) * 20'(hsj_pkg::LIM_DEN);
   assign set_x_num  = 20'(cfg.set_voltage) * 20'(hsj_pkg::LIM_NUM)
                       + 20'(hsj_pkg::LIM_ADD * hsj_pkg::LIM_DEN);
   assign over_lim   = volt_x_den > set_x_num;
   assign under_half = volt_out_ff < {1'b0, cfg.set_voltage[14:1]};
   assign at_end     = (cfg.test_duration != 14'd0)
                       && (({1'b0, in_ff.elapsed} + 15'd1) >= {1'b0, cfg.test_duration});
   assign short_cond = ((in_ff.elapsed >= 14'(hsj_pkg::SHORT_TIME))
                        || (in_ff.elapsed == cfg.test_duration))
                       && (volt_out_ff < 16'(hsj_pkg::SHORT_VOLT));
   assign active     = in_ff.judge_on && !fault_latched_ff;

   always_comb begin
      fail                   = hsj_pkg::FAIL_NONE;
      verdict                = hsj_pkg::VERDICT_NONE;
      over_volt_count_in     = over_volt_count_ff;
      under_current_count_in = under_current_count_ff;
      fault_latched_in       = in_ff.judge_on ? fault_latched_ff : 1'b0;
      if (active) begin
         priority if ((cfg.real_limit != 16'd0) && (real_out > cfg.real_limit)) begin
            fail = hsj_pkg::FAIL_REAL;
         end else if (cur_out > cfg.high_limit) begin
            fail = hsj_pkg::FAIL_HIGH;
         end else if ((in_ff.stage == hsj_pkg::STAGE_RAMP)
                      || (in_ff.stage == hsj_pkg::STAGE_SWITCH)) begin
            if (over_lim) begin
               over_volt_count_in = hsj_pkg::bump(over_volt_count_ff);
               if (over_volt_count_in > CNT_W'(hsj_pkg::OV_TRIP)) begin
                  fail = hsj_pkg::FAIL_VOLT;
               end
            end else begin
               over_volt_count_in = '0;
            end
         end else if (in_ff.stage == hsj_pkg::STAGE_DWELL) begin
            if (short_cond) begin
               fail = hsj_pkg::FAIL_SHORT;
            end else if (!at_end && (under_half || over_lim)) begin
               fail = hsj_pkg::FAIL_VOLT;
            end
            if (fail == hsj_pkg::FAIL_NONE) begin
               if (cur_out < cfg.low_limit) begin
                  under_current_count_in = hsj_pkg::bump(under_current_count_ff);
                  if (under_current_count_in >= CNT_W'(hsj_pkg::LOW_TRIP)) begin
                     fail = hsj_pkg::FAIL_LOW;
                  end
               end else begin
                  under_current_count_in = '0;
               end
            end
            if ((fail == hsj_pkg::FAIL_NONE) && at_end) begin
               verdict = (cur_out < cfg.low_limit) ? hsj_pkg::VERDICT_LOW
                                                   : hsj_pkg::VERDICT_PASS;
            end
         end
         if (fail != hsj_pkg::FAIL_NONE) begin
            fault_latched_in = 1'b1;
         end
      end
   end

   always_comb begin
      out_in.voltage_out       = volt_out_ff;
      out_in.current_out       = cur_out;
      out_in.real_current_out  = real_out;
      out_in.fail_code         = fail;
      out_in.stop_high_voltage = (fail != hsj_pkg::FAIL_NONE);
      out_in.end_verdict       = verdict;
   end

   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         in_ff <= req_payload;
      end
      if (cmd.mul_en) begin
         volt_prod_ff <= in_ff.volt_code * cfg.volt_gain;
         amp_prod_ff  <= in_ff.amp_code * cfg.amp_gain;
      end
      if (cmd.real_en) begin
         real_prod_ff <= real_prod_in;
         volt_out_ff  <= volt_out_in;
      end
      if (cmd.judge_load) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         over_volt_count_ff     <= '0;
         under_current_count_ff <= '0;
         fault_latched_ff       <= 1'b0;
      end else if (cmd.judge_load) begin
         over_volt_count_ff     <= over_volt_count_in;
         under_current_count_ff <= under_current_count_in;
         fault_latched_ff       <= fault_latched_in;
      end
   end

   a_stop_matches_fail: assert property (@(posedge clock) disable iff (reset)
      cmd.judge_load |=> (out_ff.stop_high_voltage == (out_ff.fail_code != hsj_pkg::FAIL_NONE)))
      else $error("stop and fail code disagree");

   a_latch_set_by_fault: assert property (@(posedge clock) disable iff (reset)
      $rose(fault_latched_ff) |-> ($past(cmd.judge_load) && out_ff.stop_high_voltage))
      else $error("fault latch set without a stop");

   a_verdict_without_fail: assert property (@(posedge clock) disable iff (reset)
      cmd.judge_load |=> ((out_ff.end_verdict == hsj_pkg::VERDICT_NONE)
                          || (out_ff.fail_code == hsj_pkg::FAIL_NONE)))
      else $error("end verdict given together with a fault");

endmodule
